>>> rtl/assert_macros.svh
// assertion macros shared by the framer rtl
// no dependencies; compiled away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define RPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RPF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define RPF_ASSERT(label, clk, rst_n, prop, msg)

`define RPF_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/rpf_pkg.sv
// types, constants and crc function of the packet framer
// no dependencies; used by every rpf module
package rpf_pkg;

    localparam int BUFFER_LIMIT = 72;
    localparam int MAX_PAYLOAD  = 66;
    localparam int RES_MAX      = 3;

    localparam logic [7:0]  DEST_BIT_MASK   = 8'h40;
    localparam logic [7:0]  NODE_FIELD_MASK = 8'h1F;
    localparam logic [4:0]  NODE_ALL        = 5'd31;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_PRESET      = 16'hFFFF;
    localparam logic [7:0]  GROUP_ID_RESET  = 8'd212;
    localparam logic [4:0]  NODE_ID_RESET   = 5'd1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef enum logic {
        OP_RX = 1'b0,
        OP_TX = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_GOOD      = 2'd1,
        STATUS_BAD       = 2'd2,
        STATUS_ELSEWHERE = 2'd3
    } status_t;

    typedef enum logic {
        CFG_GROUP_ID = 1'b0,
        CFG_NODE_ID  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t        op;
        logic       first;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [6:0] position;
        logic       done_res;
        status_t    status;
        logic       last;
    } out_t;

    // results of one input item handed to the output buffer
    typedef struct packed {
        logic                 load;
        logic [1:0]           cnt;
        out_t [RES_MAX-1:0]   res;
    } res_bundle_t;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/radio_packet_framer_crc16_core.sv
// top level of the radio packet framer with crc-16
// depends on rpf_pkg, rpf_in_stage, rpf_engine, rpf_out_buf, assert_macros.svh

// Takes one byte per clock while the output buffer is free. A byte is
// registered on input, processed by the engine once the output buffer is free
// (framing state and a reflected crc-16 byte update) and its results are
// registered into a three-entry output buffer, from which the first result is
// offered. Most bytes yield one result and stream at one byte per cycle while
// the output does not stall. A receive header yields two results and the final
// transmit data byte yields three (data, crc low, crc high); the output drains
// one result per cycle unless stalled, so such a byte holds off the next input
// until its last result is leaving. Stray bytes yield no result. Configuration
// writes (group id, node id) are taken every cycle.
`include "assert_macros.svh"

module radio_packet_framer_crc16_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rpf_pkg::in_t        in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rpf_pkg::out_t       out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rpf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);
    import rpf_pkg::*;

    logic [7:0]  group_id_reg;
    logic [15:0] group_seed_reg;
    logic [4:0]  node_id_reg;

    logic        item_vld;
    in_t         item;
    logic        fire;
    logic        buf_free;
    res_bundle_t bundle;

    assign cfg_ready = 1'b1;

    // configuration registers; the crc seed is kept precomputed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_id_reg   <= GROUP_ID_RESET;
            group_seed_reg <= crc_byte(CRC_PRESET, GROUP_ID_RESET);
            node_id_reg    <= NODE_ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GROUP_ID:
                begin
                    group_id_reg   <= cfg_data;
                    group_seed_reg <= crc_byte(CRC_PRESET, cfg_data);
                end
                CFG_NODE_ID:
                begin
                    node_id_reg <= cfg_data[4:0];
                end
                default:
                begin
                    node_id_reg <= node_id_reg;
                end
            endcase
        end
    end

    rpf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .fire     (fire),
        .item_vld (item_vld),
        .item     (item)
    );

    rpf_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_vld   (item_vld),
        .item       (item),
        .buf_free   (buf_free),
        .group_id   (group_id_reg),
        .group_seed (group_seed_reg),
        .node_id    (node_id_reg),
        .fire       (fire),
        .bundle     (bundle)
    );

    rpf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .bundle    (bundle),
        .buf_free  (buf_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // input only backs up behind pending results
    `RPF_ASSERT(a_stall_needs_results, clk, rst_n, in_stall |-> out_valid,
                "input stalled with empty output buffer")
    // a packet end is always the final result of its byte
    `RPF_ASSERT(a_done_is_last, clk, rst_n,
                (out_valid && out_data.done_res) |-> out_data.last,
                "done result not marked last")
    // a status is only reported on a completed packet
    `RPF_ASSERT_NEVER(a_status_without_done, clk, rst_n,
                      out_valid && (out_data.status != STATUS_NONE) && !out_data.done_res,
                      "status on a result that does not end a packet")
    // new results only enter a free buffer
    `RPF_ASSERT(a_load_when_free, clk, rst_n, bundle.load |-> buf_free,
                "results loaded into a busy buffer")

endmodule

>>> rtl/rpf_in_stage.sv
// input register of the packet framer
// depends on rpf_pkg
module rpf_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  rpf_pkg::in_t in_data,
    input  logic         fire,
    output logic         item_vld,
    output rpf_pkg::in_t item
);
    import rpf_pkg::*;

    logic vld_reg;
    in_t  data_reg;

    // hold while the engine cannot take the registered item
    assign in_stall = vld_reg && !fire;
    assign item_vld = vld_reg;
    assign item     = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!in_stall)
            vld_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            data_reg <= in_data;
    end

endmodule

>>> rtl/rpf_engine.sv
// framing engine: packet state, crc update and result generation
// depends on rpf_pkg
module rpf_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_vld,
    input  rpf_pkg::in_t         item,
    input  logic                 buf_free,
    input  logic [7:0]           group_id,
    input  logic [15:0]          group_seed,
    input  logic [4:0]           node_id,
    output logic                 fire,
    output rpf_pkg::res_bundle_t bundle
);
    import rpf_pkg::*;

    mode_t       mode_reg,   mode_next;
    logic [15:0] crc_reg,    crc_next;
    logic [6:0]  fill_reg,   fill_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  hdr_reg,    hdr_next;

    logic [7:0]  b;
    logic [6:0]  rx_pos, rx_fill;
    logic [7:0]  rx_hdr, rx_len;
    logic [15:0] rx_crc;
    logic        rx_over, rx_done, rx_for_us;
    status_t     rx_status;
    out_t        rx_res, grp_res;

    logic [7:0]  tx_hdr, tx_len, tx_count;
    logic [15:0] tx_first_crc, tx_crc;
    logic [6:0]  tx_fill;
    logic        tx_end;

    assign b    = item.data_byte;
    assign fire = item_vld && buf_free;

    // receive: store one byte, first byte lands at position 1
    assign rx_pos  = item.first ? 7'd1 : fill_reg;
    assign rx_hdr  = (rx_pos == 7'd1) ? b : hdr_reg;
    assign rx_len  = (rx_pos == 7'd2) ? b : (item.first ? 8'd0 : len_reg);
    assign rx_crc  = crc_byte(item.first ? group_seed : crc_reg, b);
    assign rx_over = rx_len > 8'(MAX_PAYLOAD);
    assign rx_fill = rx_over ? 7'(BUFFER_LIMIT) : rx_pos + 7'd1;
    assign rx_done = ({2'b00, rx_fill} >= ({1'b0, rx_len} + 9'd5))
                  || (rx_fill >= 7'(BUFFER_LIMIT));

    // address filter
    assign rx_for_us = ((rx_hdr & DEST_BIT_MASK) == 8'h00) || (node_id == NODE_ALL)
                    || ((rx_hdr & NODE_FIELD_MASK) == {3'b000, node_id});

    always_comb
    begin
        if (!rx_done)
            rx_status = STATUS_NONE;
        else if ((rx_crc != 16'h0000) || rx_over)
            rx_status = STATUS_BAD;
        else if (rx_for_us)
            rx_status = STATUS_GOOD;
        else
            rx_status = STATUS_ELSEWHERE;
    end

    assign rx_res  = '{out_byte: b, position: rx_pos, done_res: rx_done,
                       status: rx_status, last: 1'b1};
    assign grp_res = '{out_byte: group_id, position: 7'd0, done_res: 1'b0,
                       status: STATUS_NONE, last: 1'b0};

    // transmit: header gets the node id unless the destination bit is set
    assign tx_hdr       = ((b & DEST_BIT_MASK) != 8'h00) ? b
                        : (b & ~NODE_FIELD_MASK) + {3'b000, node_id};
    assign tx_first_crc = crc_byte(group_seed, tx_hdr);
    assign tx_len       = (fill_reg == 7'd2) ? b : len_reg;
    assign tx_crc       = crc_byte(crc_reg, b);
    assign tx_fill      = fill_reg + 7'd1;
    assign tx_count     = (tx_len > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : tx_len;
    assign tx_end       = {2'b00, tx_fill} >= ({1'b0, tx_count} + 9'd3);

    // next state and results
    always_comb
    begin
        mode_next  = mode_reg;
        crc_next   = crc_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        hdr_next   = hdr_reg;
        bundle     = '0;
        bundle.load = fire;
        if (fire)
        begin
            if (item.op == OP_RX)
            begin
                if (item.first || (mode_reg == MODE_RX))
                begin
                    mode_next = rx_done ? MODE_IDLE : MODE_RX;
                    crc_next  = rx_crc;
                    fill_next = rx_fill;
                    len_next  = rx_len;
                    hdr_next  = rx_hdr;
                    if (item.first)
                    begin
                        bundle.res[0] = grp_res;
                        bundle.res[1] = rx_res;
                        bundle.cnt    = 2'd2;
                    end
                    else
                    begin
                        bundle.res[0] = rx_res;
                        bundle.cnt    = 2'd1;
                    end
                end
            end
            else if (item.first)
            begin
                mode_next     = MODE_TX;
                crc_next      = tx_first_crc;
                fill_next     = 7'd2;
                len_next      = 8'd0;
                hdr_next      = tx_hdr;
                bundle.res[0] = '{out_byte: tx_hdr, position: 7'd1, done_res: 1'b0,
                                  status: STATUS_NONE, last: 1'b1};
                bundle.cnt    = 2'd1;
            end
            else if (mode_reg == MODE_TX)
            begin
                crc_next      = tx_crc;
                fill_next     = tx_fill;
                len_next      = tx_len;
                bundle.res[0] = '{out_byte: b, position: fill_reg, done_res: 1'b0,
                                  status: STATUS_NONE, last: !tx_end};
                bundle.cnt    = 2'd1;
                // crc low then high closes the packet
                if (tx_end)
                begin
                    bundle.res[1] = '{out_byte: tx_crc[7:0], position: tx_fill,
                                      done_res: 1'b0, status: STATUS_NONE, last: 1'b0};
                    bundle.res[2] = '{out_byte: tx_crc[15:8], position: tx_fill + 7'd1,
                                      done_res: 1'b1, status: STATUS_NONE, last: 1'b1};
                    bundle.cnt    = 2'd3;
                    mode_next     = MODE_IDLE;
                    fill_next     = 7'd0;
                end
            end
        end
    end

    // packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            crc_reg  <= CRC_PRESET;
            fill_reg <= 7'd0;
            len_reg  <= 8'd0;
            hdr_reg  <= 8'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            crc_reg  <= crc_next;
            fill_reg <= fill_next;
            len_reg  <= len_next;
            hdr_reg  <= hdr_next;
        end
    end

endmodule

>>> rtl/rpf_out_buf.sv
// result buffer: holds up to three results of one item and drains them in order
// depends on rpf_pkg
module rpf_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rpf_pkg::res_bundle_t bundle,
    output logic                 buf_free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rpf_pkg::out_t        out_data
);
    import rpf_pkg::*;

    logic [1:0]           rem_reg;
    out_t [RES_MAX-1:0]   ent_reg;
    logic                 take;

    assign out_valid = (rem_reg != 2'd0);
    assign out_data  = ent_reg[0];
    assign take      = out_valid && !out_stall;
    // free now, or free once the final entry leaves this cycle
    assign buf_free  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && !out_stall);

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 2'd0;
        else if (bundle.load)
            rem_reg <= bundle.cnt;
        else if (take)
            rem_reg <= rem_reg - 2'd1;
    end

    // entries shift toward the head on each transfer
    always_ff @(posedge clk)
    begin
        if (bundle.load)
            ent_reg <= bundle.res;
        else if (take)
        begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule
